FILE: sv/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Types and codes shared by the stack machine execute unit and its parts.
// ----------------------------------------------------------------------------
package smx_pkg;

	typedef enum logic [4:0] {
		KIND_NOP    = 5'd0,
		KIND_HALT   = 5'd1,
		KIND_PUSH   = 5'd2,
		KIND_POP    = 5'd3,
		KIND_ADD    = 5'd4,
		KIND_SUB    = 5'd5,
		KIND_MUL    = 5'd6,
		KIND_DIV    = 5'd7,
		KIND_GET    = 5'd8,
		KIND_PUT    = 5'd9,
		KIND_NOT    = 5'd10,
		KIND_AND    = 5'd11,
		KIND_OR     = 5'd12,
		KIND_TESTEQ = 5'd13,
		KIND_TESTNE = 5'd14,
		KIND_TESTLT = 5'd15,
		KIND_TESTLE = 5'd16,
		KIND_TESTGT = 5'd17,
		KIND_TESTGE = 5'd18,
		KIND_J      = 5'd19,
		KIND_JF     = 5'd20
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_DIV_ZERO  = 2'd1,
		ERR_UNDERFLOW = 2'd2,
		ERR_OVERFLOW  = 2'd3
	} err_t;

	// What a stack cell loads in a cycle.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_ABOVE = 2'd1,
		CELL_BELOW = 2'd2
	} cell_op_t;

	// Shift control for the cell row: the top cell and all the others.
	typedef struct packed {
		cell_op_t top_op;
		cell_op_t rest_op;
	} stk_ctl_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EXEC  = 2'd2,
		ST_DIV   = 2'd3
	} state_t;

	localparam int unsigned WORD_W = 32;

endpackage

FILE: sv/smx_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_cmd_if
// Request channel carrying one decoded instruction.
// ----------------------------------------------------------------------------
interface smx_cmd_if;
	logic        valid;
	logic        ready;
	logic [4:0]  kind;
	logic [9:0]  pc;
	logic        use_literal;
	logic [30:0] literal_value;
	logic [5:0]  var_index;
	logic [9:0]  target_pc;
	logic signed [31:0] entered_value;

	modport source (output valid, kind, pc, use_literal, literal_value, var_index,
		target_pc, entered_value, input ready);
	modport sink (input valid, kind, pc, use_literal, literal_value, var_index,
		target_pc, entered_value, output ready);
endinterface

FILE: sv/smx_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_res_if
// Result channel carrying the outcome of one instruction.
// ----------------------------------------------------------------------------
interface smx_res_if;
	logic        valid;
	logic        ready;
	logic [9:0]  next_pc;
	logic        print_valid;
	logic signed [31:0] print_value;
	logic [1:0]  error;

	modport source (output valid, next_pc, print_valid, print_value, error,
		input ready);
	modport sink (input valid, next_pc, print_valid, print_value, error,
		output ready);
endinterface

FILE: sv/smx_stack_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_stack_cell
// One entry of the shifting operand stack.
// ----------------------------------------------------------------------------
module smx_stack_cell (
	input  logic              clk,
	input  smx_pkg::cell_op_t op,
	input  logic [31:0]       above,
	input  logic [31:0]       below,
	output logic [31:0]       data
);

	logic [31:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			smx_pkg::CELL_ABOVE: data_q <= above;
			smx_pkg::CELL_BELOW: data_q <= below;
			default:             data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

FILE: sv/smx_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_divider
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smx_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			dvs_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

FILE: sv/stack_machine_execute_unit_core.sv
`timescale 1ns / 1ps
// Sequence: an instruction is accepted while idle, then executed; a division first runs
// the divider, one bit per cycle. No request is taken until the result is issued.
// Reset: clears the stack count and the control state, then a clearing pass zeroes
// the variable store, during which no request is taken.
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_core
// Executes decoded stack machine instructions against an operand stack held in
// a row of shifting cells and a variable store held in a memory.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_core #(
	parameter int STACK_DEPTH   = 64,
	parameter int VAR_COUNT     = 64,
	parameter int PROGRAM_DEPTH = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	smx_cmd_if.sink   cmd,
	smx_res_if.source res
);

	localparam int CW   = $clog2(STACK_DEPTH + 1);
	localparam int VI_W = $clog2(VAR_COUNT);
	localparam bit PC_BIG = PROGRAM_DEPTH > 1024;
	// Ceiling reciprocal, exact for the 11-bit addresses divided here.
	localparam longint unsigned RECIP = ((64'd1 << 32) + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH;

	// Wrap modulo the program depth by reciprocal multiply; modulo 1024 if deeper.
	function automatic logic [9:0] addr_wrap(input logic [10:0] a);
		logic [43:0] prod;
		logic [10:0] q;
		logic [31:0] back;
		logic [10:0] rem;
		prod = 44'(a) * 44'(RECIP);
		q    = 11'(prod >> 32);
		back = 32'(q) * 32'(PROGRAM_DEPTH);
		rem  = a - 11'(back);
		if (PC_BIG)
			return a[9:0];
		return rem[9:0];
	endfunction

	// The variable index is reduced modulo the store size through a constant map.
	logic [VI_W-1:0] vmap [64];
	for (genvar g = 0; g < 64; g++) begin : g_vmap
		assign vmap[g] = VI_W'(g % VAR_COUNT);
	end

	smx_pkg::state_t st_q, st_d;

	// Latched request fields.
	smx_pkg::kind_t  kind_q;
	logic [9:0]      pc_q;
	logic            lit_q;
	logic [30:0]     litv_q;
	logic [VI_W-1:0] vi_q;
	logic [9:0]      tgt_q;
	logic [31:0]     ent_q;

	// Variable store with a registered read port.
	logic [31:0]     var_mem [VAR_COUNT];
	logic [31:0]     var_rd_q;
	logic [VI_W-1:0] clr_q;
	logic            var_we;
	logic [VI_W-1:0] var_wa;
	logic [31:0]     var_wd;

	logic [CW-1:0] cnt_q;
	logic          quot_ok_q;
	logic [31:0]   quot_q;

	logic          ovld_q;
	logic [9:0]    onext_q;
	logic          opv_q;
	logic [31:0]   opval_q;
	logic [1:0]    oerr_q;

	logic          accept;
	logic          fire;
	logic          div_start;
	logic          div_done;
	logic [31:0]   div_quo;

	smx_pkg::stk_ctl_t ctl;
	logic [31:0]   top_din;
	logic [31:0]   cell_data [STACK_DEPTH];

	logic [31:0]   a, b, alu_r, un_r;
	smx_pkg::err_t err;
	logic [9:0]    next_pc;
	logic          neg, zero;

	assign a = cell_data[1];
	assign b = cell_data[0];
	assign neg  = b[31];
	assign zero = b == 32'd0;

	// Operand stack: cell 0 is the top, a push shifts every entry down one cell.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		smx_stack_cell u_cell (
			.clk   (clk),
			.op    (i == 0 ? ctl.top_op : ctl.rest_op),
			.above (i == 0 ? top_din : cell_data[(i == 0) ? 0 : i - 1]),
			.below (i == STACK_DEPTH - 1 ? 32'd0 :
				cell_data[(i == STACK_DEPTH - 1) ? i : i + 1]),
			.data  (cell_data[i])
		);
	end

	smx_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a),
		.divisor  (b),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign cmd.ready = st_q == smx_pkg::ST_IDLE;
	assign accept    = cmd.valid && cmd.ready;

	// Error checks: too few entries comes before divide by zero.
	always_comb begin
		err = smx_pkg::ERR_NONE;
		unique case (kind_q) inside
			smx_pkg::KIND_PUSH:
				if (cnt_q == CW'(STACK_DEPTH)) err = smx_pkg::ERR_OVERFLOW;
			smx_pkg::KIND_POP, smx_pkg::KIND_NOT, smx_pkg::KIND_TESTEQ,
			smx_pkg::KIND_TESTNE, smx_pkg::KIND_TESTLT, smx_pkg::KIND_TESTLE,
			smx_pkg::KIND_TESTGT, smx_pkg::KIND_TESTGE, smx_pkg::KIND_JF:
				if (cnt_q == '0) err = smx_pkg::ERR_UNDERFLOW;
			smx_pkg::KIND_ADD, smx_pkg::KIND_SUB, smx_pkg::KIND_MUL,
			smx_pkg::KIND_AND, smx_pkg::KIND_OR:
				if (cnt_q < CW'(2)) err = smx_pkg::ERR_UNDERFLOW;
			smx_pkg::KIND_DIV:
				if (cnt_q < CW'(2)) err = smx_pkg::ERR_UNDERFLOW;
				else if (zero) err = smx_pkg::ERR_DIV_ZERO;
			default: err = smx_pkg::ERR_NONE;
		endcase
	end

	// Two-operand results; the quotient comes from the divider.
	always_comb begin
		case (kind_q)
			smx_pkg::KIND_ADD: alu_r = a + b;
			smx_pkg::KIND_SUB: alu_r = a - b;
			smx_pkg::KIND_MUL: alu_r = a * b;
			smx_pkg::KIND_DIV: alu_r = quot_q;
			smx_pkg::KIND_AND: alu_r = {31'd0, (a != 32'd0) && (b != 32'd0)};
			default:           alu_r = {31'd0, (a != 32'd0) || (b != 32'd0)};
		endcase
	end

	// One-operand results: logical not and the tests against zero.
	always_comb begin
		case (kind_q) inside
			smx_pkg::KIND_NOT,
			smx_pkg::KIND_TESTEQ: un_r = {31'd0, zero};
			smx_pkg::KIND_TESTNE: un_r = {31'd0, !zero};
			smx_pkg::KIND_TESTLT: un_r = {31'd0, neg};
			smx_pkg::KIND_TESTLE: un_r = {31'd0, neg || zero};
			smx_pkg::KIND_TESTGT: un_r = {31'd0, !neg && !zero};
			default:              un_r = {31'd0, !neg};
		endcase
	end

	always_comb begin
		if (err != smx_pkg::ERR_NONE)
			next_pc = pc_q;
		else if (kind_q == smx_pkg::KIND_J || (kind_q == smx_pkg::KIND_JF && zero))
			next_pc = addr_wrap({1'b0, tgt_q});
		else
			next_pc = addr_wrap({1'b0, pc_q} + 11'd1);
	end

	// Sequencer: next state, divider start, stack and store updates.
	always_comb begin
		st_d      = st_q;
		fire      = 1'b0;
		div_start = 1'b0;
		ctl       = '{top_op: smx_pkg::CELL_HOLD, rest_op: smx_pkg::CELL_HOLD};
		top_din   = alu_r;
		var_we    = 1'b0;
		var_wa    = vi_q;
		var_wd    = ent_q;
		unique case (st_q)
			smx_pkg::ST_CLEAR: begin
				var_we = 1'b1;
				var_wa = clr_q;
				var_wd = '0;
				if (clr_q == VI_W'(VAR_COUNT - 1)) st_d = smx_pkg::ST_IDLE;
			end
			smx_pkg::ST_IDLE: begin
				if (accept) st_d = smx_pkg::ST_EXEC;
			end
			smx_pkg::ST_EXEC: begin
				if (kind_q == smx_pkg::KIND_DIV && err == smx_pkg::ERR_NONE && !quot_ok_q) begin
					div_start = 1'b1;
					st_d      = smx_pkg::ST_DIV;
				end else if (!ovld_q || res.ready) begin
					fire = 1'b1;
					st_d = smx_pkg::ST_IDLE;
					if (err == smx_pkg::ERR_NONE) begin
						case (kind_q) inside
							smx_pkg::KIND_PUSH: begin
								ctl     = '{top_op: smx_pkg::CELL_ABOVE,
									rest_op: smx_pkg::CELL_ABOVE};
								top_din = lit_q ? {1'b0, litv_q} : var_rd_q;
							end
							smx_pkg::KIND_POP: begin
								ctl    = '{top_op: smx_pkg::CELL_BELOW,
									rest_op: smx_pkg::CELL_BELOW};
								var_we = 1'b1;
								var_wd = b;
							end
							smx_pkg::KIND_JF:
								ctl = '{top_op: smx_pkg::CELL_BELOW,
									rest_op: smx_pkg::CELL_BELOW};
							smx_pkg::KIND_ADD, smx_pkg::KIND_SUB, smx_pkg::KIND_MUL,
							smx_pkg::KIND_DIV, smx_pkg::KIND_AND, smx_pkg::KIND_OR:
								ctl = '{top_op: smx_pkg::CELL_ABOVE,
									rest_op: smx_pkg::CELL_BELOW};
							smx_pkg::KIND_NOT, smx_pkg::KIND_TESTEQ, smx_pkg::KIND_TESTNE,
							smx_pkg::KIND_TESTLT, smx_pkg::KIND_TESTLE,
							smx_pkg::KIND_TESTGT, smx_pkg::KIND_TESTGE: begin
								ctl     = '{top_op: smx_pkg::CELL_ABOVE,
									rest_op: smx_pkg::CELL_HOLD};
								top_din = un_r;
							end
							smx_pkg::KIND_GET:
								var_we = 1'b1;
							default: ;
						endcase
					end
				end
			end
			smx_pkg::ST_DIV: begin
				if (div_done) st_d = smx_pkg::ST_EXEC;
			end
			default: st_d = smx_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= smx_pkg::ST_CLEAR;
			clr_q     <= '0;
			cnt_q     <= '0;
			quot_ok_q <= 1'b0;
			ovld_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == smx_pkg::ST_CLEAR) clr_q <= clr_q + VI_W'(1);
			if (st_q == smx_pkg::ST_DIV && div_done) quot_ok_q <= 1'b1;
			if (fire) quot_ok_q <= 1'b0;
			if (fire) ovld_q <= 1'b1;
			else if (res.ready) ovld_q <= 1'b0;
			if (fire && err == smx_pkg::ERR_NONE) begin
				case (kind_q) inside
					smx_pkg::KIND_PUSH: cnt_q <= cnt_q + CW'(1);
					smx_pkg::KIND_POP, smx_pkg::KIND_JF, smx_pkg::KIND_ADD,
					smx_pkg::KIND_SUB, smx_pkg::KIND_MUL, smx_pkg::KIND_DIV,
					smx_pkg::KIND_AND, smx_pkg::KIND_OR: cnt_q <= cnt_q - CW'(1);
					default: ;
				endcase
			end
		end
	end

	// Request fields, the store read and the result payload carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= smx_pkg::kind_t'(cmd.kind);
			pc_q     <= cmd.pc;
			lit_q    <= cmd.use_literal;
			litv_q   <= cmd.literal_value;
			vi_q     <= vmap[cmd.var_index];
			tgt_q    <= cmd.target_pc;
			ent_q    <= cmd.entered_value;
			var_rd_q <= var_mem[vmap[cmd.var_index]];
		end
		if (st_q == smx_pkg::ST_DIV && div_done) quot_q <= div_quo;
		if (fire) begin
			onext_q <= next_pc;
			opv_q   <= kind_q == smx_pkg::KIND_PUT;
			opval_q <= (kind_q == smx_pkg::KIND_PUT) ? var_rd_q : 32'd0;
			oerr_q  <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (var_we) var_mem[var_wa] <= var_wd;
	end

	assign res.valid       = ovld_q;
	assign res.next_pc     = onext_q;
	assign res.print_valid = opv_q;
	assign res.print_value = opval_q;
	assign res.error       = oerr_q;

endmodule
